[design/tmps_pkg.sv]
package tmps_pkg;

  // Partial sums and the result are 24-bit two's complement.
  localparam int SUM_W = 24;
  localparam int ELEM_W = 16;
  localparam int STATUS_W = 2;

  localparam int MAX_ROWS_DEFAULT = 256;

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_SHORT    = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  // Memory port bundle between the top level and the row buffer.
  typedef struct packed {
    logic re;
    logic we;
  } mem_ctrl_t;

  // Saturating add of one element onto a 24-bit partial sum.
  function automatic logic signed [SUM_W-1:0] sat_add(
    input logic signed [ELEM_W-1:0] value,
    input logic signed [SUM_W-1:0]  best
  );
    logic signed [SUM_W:0] wide;
    wide = {{(SUM_W+1-ELEM_W){value[ELEM_W-1]}}, value} + {best[SUM_W-1], best};
    if (wide[SUM_W] != wide[SUM_W-1]) begin
      return wide[SUM_W] ? SUM_MIN : SUM_MAX;
    end
    return wide[SUM_W-1:0];
  endfunction

endpackage

[design/tmps_row_mem.sv]
module tmps_row_mem import tmps_pkg::*; #(
  parameter int DEPTH = MAX_ROWS_DEFAULT,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                    clk,
  input  mem_ctrl_t               ctrl,
  input  logic [AW-1:0]           raddr,
  input  logic [AW-1:0]           waddr,
  input  logic signed [SUM_W-1:0] wdata,
  output logic signed [SUM_W-1:0] rdata
);

  logic signed [SUM_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctrl.we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read-during-write to the same entry returns the new data.
  always_ff @(posedge clk) begin
    if (ctrl.re) begin
      if (ctrl.we && (waddr == raddr)) begin
        rdata <= wdata;
      end else begin
        rdata <= mem[raddr];
      end
    end
  end

endmodule

[design/triangle_min_path_sum.sv]
// Minimum top-to-bottom path sum of a number triangle. Elements stream in
// row by row from the apex (row r carries r+1 elements), one transfer per
// clock; the block takes one element every cycle with no bubbles while a
// finished result waits on out_stall, and only stalls the input when a second
// is_last element reaches stage 1 before the waiting result has gone out.
// The element flagged by is_last loads the output register from the stage 1
// registers: the row buffer read issues at the transfer edge, and the add,
// compare and write back happen in stage 1. The registered memory read is
// why stage 1 exists; throughput is one per cycle while no stall holds it.
// path_sum saturates to 24-bit signed. status is 0 when the last row was
// complete, 1 when it was cut short (path_sum then 0), 2 when more than
// MAX_ROWS rows arrived (extra elements are dropped, path_sum covers the
// first MAX_ROWS rows). After a result the block starts a fresh triangle.
module triangle_min_path_sum import tmps_pkg::*; #(
  parameter int MAX_ROWS = MAX_ROWS_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [ELEM_W-1:0]   elem_value,
  input  logic                       is_last,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [SUM_W-1:0]    path_sum,
  output logic [STATUS_W-1:0]        status
);

  localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;  // column / address
  localparam int RW = $clog2(MAX_ROWS + 1);                    // row, holds MAX_ROWS

  // Per-element decisions made at transfer time, registered for use in stage 1.
  typedef struct packed {
    logic first;      // column 0: starts the row minimum
    logic apex;       // row 0: no row above
    logic use_above;  // column has an entry in the row above
    logic row_end;    // rightmost element of its row
    logic skip;       // beyond MAX_ROWS rows, dropped
    logic ovf;        // overflow seen in this triangle so far
    logic last;
  } s1_ctrl_t;

  // ---------------- stage 0: sequencing, memory read ----------------
  logic [RW-1:0] row_index;
  logic [AW-1:0] col_index;
  logic          overflow_seen;

  logic          in_xfer;
  logic          s1_adv;
  logic          s1_valid;
  logic          s0_skip;
  logic          s0_row_end;
  s1_ctrl_t      s0_ctrl;

  assign in_xfer    = in_valid && !in_stall;
  assign s0_skip    = (row_index >= RW'(MAX_ROWS));
  assign s0_row_end = !s0_skip && (RW'(col_index) >= row_index);

  always_comb begin
    s0_ctrl.first     = (col_index == '0);
    s0_ctrl.apex      = (row_index == '0);
    s0_ctrl.use_above = (RW'(col_index) < row_index);
    s0_ctrl.row_end   = s0_row_end;
    s0_ctrl.skip      = s0_skip;
    s0_ctrl.ovf       = overflow_seen || s0_skip;
    s0_ctrl.last      = is_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_index     <= '0;
      col_index     <= '0;
      overflow_seen <= 1'b0;
    end else if (in_xfer) begin
      if (is_last) begin
        row_index     <= '0;
        col_index     <= '0;
        overflow_seen <= 1'b0;
      end else if (s0_skip) begin
        overflow_seen <= 1'b1;
      end else if (s0_row_end) begin
        row_index <= row_index + RW'(1);
        col_index <= '0;
      end else begin
        col_index <= col_index + AW'(1);
      end
    end
  end

  // ---------------- stage 1: combine with row above, write back ----------------
  s1_ctrl_t                s1_ctrl;
  logic signed [ELEM_W-1:0] s1_value;
  logic [AW-1:0]           s1_col;
  logic signed [SUM_W-1:0] rdata;

  logic signed [SUM_W-1:0] held_left_sum;
  logic signed [SUM_W-1:0] row_min;

  logic signed [SUM_W-1:0] above;
  logic signed [SUM_W-1:0] best;
  logic signed [SUM_W-1:0] fresh;
  logic signed [SUM_W-1:0] row_min_next;
  mem_ctrl_t               mem_ctrl;

  // Stage 1 only waits when it holds a result and the output register is
  // still full and stalled.
  assign s1_adv   = s1_valid && !(s1_ctrl.last && out_valid && out_stall);
  assign in_stall = s1_valid && !s1_adv;

  always_comb begin
    above = s1_ctrl.use_above ? rdata : '0;
    if (s1_ctrl.apex) begin
      best = '0;
    end else if (s1_ctrl.first) begin
      best = above;
    end else if (s1_ctrl.row_end) begin
      best = held_left_sum;
    end else begin
      best = (held_left_sum < above) ? held_left_sum : above;
    end
    fresh = sat_add(s1_value, best);
    if (s1_ctrl.skip) begin
      row_min_next = row_min;
    end else if (s1_ctrl.first || (fresh < row_min)) begin
      row_min_next = fresh;
    end else begin
      row_min_next = row_min;
    end
  end

  assign mem_ctrl.re = in_xfer && !s0_skip;
  assign mem_ctrl.we = s1_adv && !s1_ctrl.skip;

  tmps_row_mem #(
    .DEPTH (MAX_ROWS),
    .AW    (AW)
  ) u_row_mem (
    .clk   (clk),
    .ctrl  (mem_ctrl),
    .raddr (col_index),
    .waddr (s1_col),
    .wdata (fresh),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_xfer) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_ctrl  <= s0_ctrl;
      s1_value <= elem_value;
      s1_col   <= col_index;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_left_sum <= '0;
      row_min       <= '0;
    end else if (s1_adv) begin
      if (s1_ctrl.last) begin
        held_left_sum <= '0;
        row_min       <= '0;
      end else if (!s1_ctrl.skip) begin
        held_left_sum <= above;
        row_min       <= row_min_next;
      end
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv && s1_ctrl.last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_ctrl.last) begin
      if (s1_ctrl.ovf) begin
        path_sum <= row_min_next;
        status   <= ST_OVERFLOW;
      end else if (s1_ctrl.row_end) begin
        path_sum <= row_min_next;
        status   <= ST_OK;
      end else begin
        path_sum <= '0;
        status   <= ST_SHORT;
      end
    end
  end

endmodule
